### hdl/srs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srs_pkg - shared types and constants of the systematic resampler
// Item and result structs, register map, state codes and fixed field widths.
// ----------------------------------------------------------------------------
package srs_pkg;

  // fixed-point format of weights and offsets
  localparam int FRAC_BITS = 24;
  localparam int WEIGHT_W  = FRAC_BITS + 1;
  localparam int OFFSET_W  = FRAC_BITS;
  localparam int SUM_W     = FRAC_BITS + 2;
  localparam int THR_W     = 32;

  // register fields
  localparam int PCOUNT_W  = 7;
  localparam int SPACING_W = FRAC_BITS + 1;
  localparam int SLOT_W    = 6;

  // configuration bus
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [PCOUNT_W-1:0]  PCOUNT_RESET  = 7'd64;
  localparam logic [SPACING_W-1:0] SPACING_RESET = 25'd262144;

  // register index, taken from paddr[2]
  localparam logic REG_PARTICLE_COUNT = 1'b0;
  localparam logic REG_SPACING        = 1'b1;

  // item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_START = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [WEIGHT_W-1:0] weight;
    logic [OFFSET_W-1:0] offset;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] ancestor;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [PCOUNT_W-1:0]  particle_count;
    logic [SPACING_W-1:0] spacing;
  } cfg_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

endpackage : srs_pkg
`default_nettype wire

### hdl/srs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srs_ram - generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module srs_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule : srs_ram
`default_nettype wire

### hdl/srs_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srs_regs - configuration registers
// APB-style slave holding particle_count (0x0) and spacing (0x4).
// ----------------------------------------------------------------------------
module srs_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [srs_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [srs_pkg::PDATA_W-1:0]  pwdata,
  output logic      [srs_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output srs_pkg::cfg_t                     cfg
);

  import srs_pkg::*;

  logic reg_index;

  assign reg_index = paddr[2];
  assign pready    = 1'b1;

  // register write on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.particle_count <= PCOUNT_RESET;
      cfg.spacing        <= SPACING_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_index)
        REG_PARTICLE_COUNT: cfg.particle_count <= pwdata[PCOUNT_W-1:0];
        REG_SPACING:        cfg.spacing        <= pwdata[SPACING_W-1:0];
        default:            ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_index)
      REG_PARTICLE_COUNT: prdata = PDATA_W'(cfg.particle_count);
      REG_SPACING:        prdata = PDATA_W'(cfg.spacing);
      default:            prdata = '0;
    endcase
  end

endmodule : srs_regs
`default_nettype wire

### hdl/srs_walk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srs_walk - load and search sequencer
// Builds the cumulative weight table in RAM and walks it for each start.
// ----------------------------------------------------------------------------
module srs_walk #(
  parameter int NUM_PARTICLES = 64
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire srs_pkg::cfg_t                        cfg,
  input  wire logic                                 item_valid,
  output logic                                      item_stall,
  input  wire srs_pkg::item_t                       item,
  output logic                                      result_valid,
  input  wire logic                                 result_stall,
  output srs_pkg::result_t                          result,
  output logic                                      ram_we,
  output logic [$clog2(NUM_PARTICLES)-1:0]          ram_waddr,
  output logic [srs_pkg::SUM_W-1:0]                 ram_wdata,
  output logic [$clog2(NUM_PARTICLES)-1:0]          ram_raddr,
  input  wire logic [srs_pkg::SUM_W-1:0]            ram_rdata
);

  import srs_pkg::*;

  localparam int IDX_W = $clog2(NUM_PARTICLES);
  localparam int CNT_W = $clog2(NUM_PARTICLES + 1);

  state_t             state, state_next;
  logic [CNT_W-1:0]   load_pointer, load_pointer_next;
  logic [SUM_W-1:0]   running_sum, running_sum_next;
  logic [IDX_W-1:0]   search_index, search_index_next;
  logic [THR_W-1:0]   threshold, threshold_next;
  logic [IDX_W-1:0]   slot_count, slot_count_next;

  logic [CNT_W-1:0]   count_eff;
  logic [CNT_W-1:0]   limit;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_sat;
  logic [THR_W:0]     thr_wide;
  logic [THR_W-1:0]   thr_sat;
  logic               advance;
  logic               slot_last;
  logic               emit;
  logic               emit_ok;

  // effective particle count, clamped to 1..NUM_PARTICLES
  always_comb begin
    if (cfg.particle_count == '0) begin
      count_eff = CNT_W'(1);
    end else if (cfg.particle_count > PCOUNT_W'(NUM_PARTICLES)) begin
      count_eff = CNT_W'(NUM_PARTICLES);
    end else begin
      count_eff = cfg.particle_count[CNT_W-1:0];
    end
  end

  // saturating accumulators
  assign sum_wide = {1'b0, running_sum} + (SUM_W + 1)'(item.weight);
  assign sum_sat  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  assign thr_wide = {1'b0, threshold} + (THR_W + 1)'(cfg.spacing);
  assign thr_sat  = thr_wide[THR_W] ? {THR_W{1'b1}} : thr_wide[THR_W-1:0];

  // search stops at the last particle loaded this round
  assign limit     = (load_pointer == '0) ? '0 : load_pointer - CNT_W'(1);
  assign advance   = (load_pointer != '0) && (CNT_W'(search_index) < limit) &&
                     (threshold > THR_W'(ram_rdata));
  assign slot_last = (CNT_W'(slot_count) == count_eff - CNT_W'(1));
  assign emit_ok   = !result_valid || !result_stall;

  // RAM ports: read address follows the next search index so data lines up
  assign ram_waddr = load_pointer[IDX_W-1:0];
  assign ram_wdata = sum_sat;
  assign ram_raddr = search_index_next;

  // state register and walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      load_pointer <= '0;
      running_sum  <= '0;
      search_index <= '0;
      threshold    <= '0;
      slot_count   <= '0;
    end else begin
      state        <= state_next;
      load_pointer <= load_pointer_next;
      running_sum  <= running_sum_next;
      search_index <= search_index_next;
      threshold    <= threshold_next;
      slot_count   <= slot_count_next;
    end
  end

  // next state and control
  always_comb begin
    state_next        = state;
    load_pointer_next = load_pointer;
    running_sum_next  = running_sum;
    search_index_next = search_index;
    threshold_next    = threshold;
    slot_count_next   = slot_count;
    ram_we            = 1'b0;
    emit              = 1'b0;
    item_stall        = 1'b1;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          if (item.kind == KIND_LOAD) begin
            // loads past the particle count are dropped
            if (load_pointer < count_eff) begin
              running_sum_next  = sum_sat;
              ram_we            = 1'b1;
              load_pointer_next = load_pointer + CNT_W'(1);
            end
          end else begin
            threshold_next    = THR_W'(item.offset);
            search_index_next = '0;
            slot_count_next   = '0;
            state_next        = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (advance) begin
          search_index_next = search_index + IDX_W'(1);
        end else if (emit_ok) begin
          emit           = 1'b1;
          threshold_next = thr_sat;
          if (slot_last) begin
            load_pointer_next = '0;
            running_sum_next  = '0;
            state_next        = ST_IDLE;
          end else begin
            slot_count_next = slot_count + IDX_W'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.slot     <= SLOT_W'(slot_count);
      result.ancestor <= SLOT_W'(search_index);
      result.last     <= slot_last;
    end
  end

endmodule : srs_walk
`default_nettype wire

### hdl/systematic_resampler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// systematic_resampler - particle-filter systematic resampler
// Keeps cumulative Q2.24 weights in RAM and emits one ancestor per slot.
// ----------------------------------------------------------------------------
//  channel   signals                              direction
//  item      item_valid, item_stall, item         in  (load weight / start)
//  result    result_valid, result_stall, result   out (slot, ancestor, last)
//  config    psel, penable, pwrite, paddr, ...    APB slave, 2 registers
//
//  A start emits n results, where n is the particle count, over k (at most
//  n - 1) search steps plus stalls; each step does one registered RAM read
//  and one compare. No clearing pass after reset.
//  A stalled result holds the walk at its next slot; the input is stalled
//  during a search.
// ----------------------------------------------------------------------------
module systematic_resampler #(
  parameter int NUM_PARTICLES = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire srs_pkg::item_t              item,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output srs_pkg::result_t                 result,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [srs_pkg::PADDR_W-1:0] paddr,
  input  wire logic [srs_pkg::PDATA_W-1:0] pwdata,
  output logic      [srs_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);

  import srs_pkg::*;

  localparam int IDX_W = $clog2(NUM_PARTICLES);

  cfg_t             cfg;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [SUM_W-1:0] ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [SUM_W-1:0] ram_rdata;

  // configuration registers
  srs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // load and search sequencer
  srs_walk #(
    .NUM_PARTICLES (NUM_PARTICLES)
  ) u_walk (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  // cumulative weight table
  srs_ram #(
    .WIDTH (SUM_W),
    .DEPTH (NUM_PARTICLES)
  ) u_cum_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a start always opens a search, which blocks further items
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.kind == KIND_START) |=> item_stall)
    else $error("start transfer did not begin a search");

  // ancestors and slots stay inside the particle table
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ({1'b0, result.ancestor} < (SLOT_W + 1)'(NUM_PARTICLES) &&
                      {1'b0, result.slot} < (SLOT_W + 1)'(NUM_PARTICLES)))
    else $error("result index beyond particle table");

  // a new result never appears while the input side is open
  assert property (@(posedge clk) disable iff (rst)
    (!item_stall && !(result_valid && result_stall)) |=> !result_valid ||
      $past(item_stall) == 1'b1 || $past(result_valid && result_stall) ||
      !$past(!item_stall))
    else $error("result produced outside a search");

endmodule : systematic_resampler
`default_nettype wire
